FILE: rtl/vfcm_pkg.sv
`default_nettype none

package vfcm_pkg;

   localparam int NumVert = 24;
   localparam int NumIdx  = 36;
   localparam int NumTri  = 12;

   typedef enum logic {
      KIND_VERTEX = 1'b0,
      KIND_INDEX  = 1'b1
   } kind_type;

   typedef struct packed {
      logic       cx;
      logic       cy;
      logic       cz;
      logic [2:0] nrm;
      logic [2:0] u;
      logic [2:0] v;
   } corner_type;

   // Cube corners in emission order: offset, face normal code and texture corner.
   localparam corner_type CubeTab [NumVert] = '{
      '{1'b0, 1'b1, 1'b0, 3'd2, 3'd2, 3'd5},
      '{1'b1, 1'b1, 1'b1, 3'd2, 3'd1, 3'd6},
      '{1'b1, 1'b1, 1'b0, 3'd2, 3'd1, 3'd5},
      '{1'b1, 1'b1, 1'b1, 3'd4, 3'd3, 3'd6},
      '{1'b0, 1'b0, 1'b1, 3'd4, 3'd2, 3'd5},
      '{1'b1, 1'b0, 1'b1, 3'd4, 3'd3, 3'd5},
      '{1'b0, 1'b1, 1'b1, 3'd1, 3'd6, 3'd6},
      '{1'b0, 1'b0, 1'b0, 3'd1, 3'd5, 3'd5},
      '{1'b0, 1'b0, 1'b1, 3'd1, 3'd6, 3'd5},
      '{1'b1, 1'b0, 1'b0, 3'd3, 3'd1, 3'd6},
      '{1'b0, 1'b0, 1'b1, 3'd3, 3'd0, 3'd5},
      '{1'b0, 1'b0, 1'b0, 3'd3, 3'd1, 3'd5},
      '{1'b1, 1'b1, 1'b0, 3'd0, 3'd4, 3'd6},
      '{1'b1, 1'b0, 1'b1, 3'd0, 3'd3, 3'd5},
      '{1'b1, 1'b0, 1'b0, 3'd0, 3'd4, 3'd5},
      '{1'b0, 1'b1, 1'b0, 3'd5, 3'd5, 3'd6},
      '{1'b1, 1'b0, 1'b0, 3'd5, 3'd4, 3'd5},
      '{1'b0, 1'b0, 1'b0, 3'd5, 3'd5, 3'd5},
      '{1'b0, 1'b1, 1'b1, 3'd2, 3'd2, 3'd6},
      '{1'b0, 1'b1, 1'b1, 3'd4, 3'd2, 3'd6},
      '{1'b1, 1'b1, 1'b1, 3'd0, 3'd3, 3'd6},
      '{1'b0, 1'b1, 1'b0, 3'd1, 3'd5, 3'd6},
      '{1'b1, 1'b1, 1'b0, 3'd5, 3'd4, 3'd6},
      '{1'b1, 1'b0, 1'b1, 3'd3, 3'd0, 3'd6}
   };

   localparam logic [4:0] TriTab [NumIdx] = '{
      5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,
      5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17,
      5'd0,  5'd18, 5'd1,  5'd3,  5'd19, 5'd4,  5'd12, 5'd20, 5'd13,
      5'd6,  5'd21, 5'd7,  5'd15, 5'd22, 5'd16, 5'd9,  5'd23, 5'd10
   };

endpackage

`default_nettype wire

FILE: rtl/voxel_face_cull_mesher_core.sv
// The first result is registered from the corner scan once a block is accepted,
// at the first corner that lies on a visible face; corners on occluded faces are skipped.
// Each block is accepted, its corner table and then its triangle index table are
// scanned, and the vertex base is updated; a stalled output holds either scan.
// A new block is only accepted once the block before it is through (req_stall).
// Reset clears the sequencer, the output valid, the vertex count and the vertex base.
`default_nettype none

module voxel_face_cull_mesher_core #(
   parameter int INDEX_BITS = 20
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_chunk_start,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic        [7:0]  req_pos_y,
   input  wire logic signed [15:0] req_pos_z,
   input  wire logic        [5:0]  req_occluded_faces,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_kind,
   output logic signed      [15:0] rsp_vert_x,
   output logic             [8:0]  rsp_vert_y,
   output logic signed      [15:0] rsp_vert_z,
   output logic             [2:0]  rsp_normal_code,
   output logic             [2:0]  rsp_tex_u_sixths,
   output logic             [2:0]  rsp_tex_v_sixths,
   output logic             [19:0] rsp_index_value,
   output logic                    rsp_index_overflow,
   output logic                    rsp_last
);
   import vfcm_pkg::*;

   localparam int BaseW = INDEX_BITS + 1;
   localparam logic [BaseW-1:0] Limit = BaseW'(1) << INDEX_BITS;
   localparam logic [4:0] VertMax = 5'(NumVert - 1);
   localparam logic [5:0] IdxMax  = 6'(NumIdx - 1);
   localparam logic [1:0] CornerMax = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_VERT,
      ST_IDX,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic [BaseW-1:0] base_ff, base_in;
   logic signed [15:0] pos_x_ff, pos_x_in;
   logic [7:0] pos_y_ff, pos_y_in;
   logic signed [15:0] pos_z_ff, pos_z_in;
   logic [5:0] occ_ff, occ_in;
   logic [4:0] vi_ff, vi_in;
   logic [4:0] nused_ff, nused_in;
   logic [5:0] k_ff, k_in;
   logic [3:0] t_ff, t_in;
   logic [1:0] j_ff, j_in;
   logic [4:0] rank_ff [NumVert];
   logic [4:0] rank_in [NumVert];

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_kind_ff, rsp_kind_in;
   logic signed [15:0] rsp_vert_x_ff, rsp_vert_x_in;
   logic [8:0] rsp_vert_y_ff, rsp_vert_y_in;
   logic signed [15:0] rsp_vert_z_ff, rsp_vert_z_in;
   logic [2:0] rsp_normal_ff, rsp_normal_in;
   logic [2:0] rsp_u_ff, rsp_u_in;
   logic [2:0] rsp_v_ff, rsp_v_in;
   logic [19:0] rsp_index_ff, rsp_index_in;
   logic rsp_ovf_ff, rsp_ovf_in;
   logic rsp_last_ff, rsp_last_in;

   logic [NumTri-1:0] keep;
   logic [NumTri-1:0] keep_after;
   logic out_free;
   corner_type corner;
   logic used;
   logic [4:0] add_opnd;
   logic [BaseW-1:0] add_sum;
   logic [BaseW+19:0] idx_ext;

   // A triangle survives when the neighbor on its face side is empty.
   always_comb begin
      for (int t = 0; t < NumTri; t++) begin
         keep[t] = !occ_ff[CubeTab[TriTab[3*t]].nrm];
      end
   end

   assign keep_after = keep >> t_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign corner     = CubeTab[vi_ff];
   assign used       = !occ_ff[corner.nrm];

   // Shared adder: base plus rank while indexing, base plus vertex count at the end.
   assign add_opnd = (state_ff == ST_IDX) ? rank_ff[TriTab[k_ff]] : nused_ff;
   assign add_sum  = base_ff + {{(BaseW-5){1'b0}}, add_opnd};
   assign idx_ext  = {20'd0, 1'b0, add_sum[INDEX_BITS-1:0]};

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      pos_z_in      = pos_z_ff;
      occ_in        = occ_ff;
      vi_in         = vi_ff;
      nused_in      = nused_ff;
      k_in          = k_ff;
      t_in          = t_ff;
      j_in          = j_ff;
      rank_in       = rank_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_vert_x_in = rsp_vert_x_ff;
      rsp_vert_y_in = rsp_vert_y_ff;
      rsp_vert_z_in = rsp_vert_z_ff;
      rsp_normal_in = rsp_normal_ff;
      rsp_u_in      = rsp_u_ff;
      rsp_v_in      = rsp_v_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pos_x_in = req_pos_x;
               pos_y_in = req_pos_y;
               pos_z_in = req_pos_z;
               occ_in   = req_occluded_faces;
               if (req_chunk_start) begin
                  base_in = '0;
               end
               vi_in    = '0;
               nused_in = '0;
               state_in = ST_VERT;
            end
         end
         ST_VERT: begin
            if (out_free) begin
               if (used) begin
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = KIND_VERTEX;
                  rsp_vert_x_in  = pos_x_ff + {15'd0, corner.cx};
                  rsp_vert_y_in  = {1'b0, pos_y_ff} + {8'd0, corner.cy};
                  rsp_vert_z_in  = pos_z_ff + {15'd0, corner.cz};
                  rsp_normal_in  = corner.nrm;
                  rsp_u_in       = corner.u;
                  rsp_v_in       = corner.v;
                  rsp_index_in   = '0;
                  rsp_ovf_in     = 1'b0;
                  rsp_last_in    = 1'b0;
                  rank_in[vi_ff] = nused_ff;
                  nused_in       = nused_ff + 5'd1;
               end
               if (vi_ff == VertMax) begin
                  k_in     = '0;
                  t_in     = '0;
                  j_in     = '0;
                  state_in = ST_IDX;
               end else begin
                  vi_in = vi_ff + 5'd1;
               end
            end
         end
         ST_IDX: begin
            if (out_free) begin
               if (keep[t_ff]) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_INDEX;
                  rsp_vert_x_in = '0;
                  rsp_vert_y_in = '0;
                  rsp_vert_z_in = '0;
                  rsp_normal_in = '0;
                  rsp_u_in      = '0;
                  rsp_v_in      = '0;
                  rsp_index_in  = idx_ext[19:0];
                  rsp_ovf_in    = add_sum[INDEX_BITS];
                  rsp_last_in   = (j_ff == CornerMax) && (keep_after[NumTri-1:1] == '0);
               end
               if (j_ff == CornerMax) begin
                  j_in = '0;
                  t_in = t_ff + 4'd1;
               end else begin
                  j_in = j_ff + 2'd1;
               end
               k_in = k_ff + 6'd1;
               if (k_ff == IdxMax) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            base_in  = (add_sum > Limit) ? Limit : add_sum;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         nused_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         nused_ff     <= nused_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_x_ff      <= pos_x_in;
      pos_y_ff      <= pos_y_in;
      pos_z_ff      <= pos_z_in;
      occ_ff        <= occ_in;
      vi_ff         <= vi_in;
      k_ff          <= k_in;
      t_ff          <= t_in;
      j_ff          <= j_in;
      rank_ff       <= rank_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_vert_x_ff <= rsp_vert_x_in;
      rsp_vert_y_ff <= rsp_vert_y_in;
      rsp_vert_z_ff <= rsp_vert_z_in;
      rsp_normal_ff <= rsp_normal_in;
      rsp_u_ff      <= rsp_u_in;
      rsp_v_ff      <= rsp_v_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_vert_x         = rsp_vert_x_ff;
   assign rsp_vert_y         = rsp_vert_y_ff;
   assign rsp_vert_z         = rsp_vert_z_ff;
   assign rsp_normal_code    = rsp_normal_ff;
   assign rsp_tex_u_sixths   = rsp_u_ff;
   assign rsp_tex_v_sixths   = rsp_v_ff;
   assign rsp_index_value    = rsp_index_ff;
   assign rsp_index_overflow = rsp_ovf_ff;
   assign rsp_last           = rsp_last_ff;

   a_base_saturated: assert property (@(posedge clock) disable iff (reset)
      base_ff <= Limit)
      else $error("vertex base went past the index limit");

   a_nused_bound: assert property (@(posedge clock) disable iff (reset)
      nused_ff <= 5'(NumVert))
      else $error("vertex count exceeds the corner table");

   a_last_on_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind == KIND_INDEX)
      else $error("last flag set on a vertex record");

   a_vertex_no_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_VERTEX |-> rsp_index_value == '0 && !rsp_index_overflow)
      else $error("vertex record carries index data");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_VERT)
      else $error("accepted block did not start the corner scan");

endmodule

`default_nettype wire
